[design/masked_threshold_centroid_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the masked threshold centroid block
// Shorthand for clocked implications, sampled on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef MASKED_THRESHOLD_CENTROID_TOP_MACROS_SVH
`define MASKED_THRESHOLD_CENTROID_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define MTC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define MTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/mtc_pkg.sv]
// ----------------------------------------------------------------------------
// mtc_pkg
// Shared widths, register indexes and types of the masked threshold centroid.
// ----------------------------------------------------------------------------
package mtc_pkg;

  // Parameter defaults
  localparam int unsigned MAX_COLS_DEF  = 1024;
  localparam int unsigned MAX_ROWS_DEF  = 1024;
  localparam int unsigned FRAC_BITS_DEF = 8;

  // Field widths
  localparam int unsigned COORD_W = 10;
  localparam int unsigned VALUE_W = 8;
  localparam int unsigned EDGE_W  = 12;
  localparam int unsigned THR_W   = 9;
  localparam int unsigned LIM_W   = 13;
  localparam int unsigned MASS_W  = 20;
  localparam int unsigned MOM_W   = 30;
  localparam int unsigned FX_W    = 19;
  localparam int unsigned PROBE_W = 11;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // Frame queue depth
  localparam int unsigned QDEPTH = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_FIRST_COL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_LAST_COL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_FIRST_ROW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_LAST_ROW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_THRESHOLD = 3'd4;

  // Accumulated totals of one finished frame
  typedef struct packed {
    logic [MASS_W-1:0] mass;
    logic [MOM_W-1:0]  row_mom;
    logic [MOM_W-1:0]  col_mom;
  } mtc_frame_t;

  // Queue occupancy flags
  typedef struct packed {
    logic full;
    logic empty;
  } mtc_fifo_stat_t;

endpackage

[design/masked_threshold_centroid_top.sv]
// Pixels: one accepted per cycle; a pixel stalls only while the frame queue
// (two frames) is full.
// Result: the totals of a finished frame pass through the queue and the
// bit-serial divider, which yields one quotient bit a cycle, into the output register.
// Reset: asynchronous, active low; clears accumulators, queue, divider control
// and the output valid; configuration returns to its documented values.
// ----------------------------------------------------------------------------
// masked_threshold_centroid_top
// Thresholded, masked centroid of a raster frame with a decoupled divider.
// ----------------------------------------------------------------------------
module masked_threshold_centroid_top #(
  parameter int unsigned MAX_COLS  = mtc_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS  = mtc_pkg::MAX_ROWS_DEF,
  parameter int unsigned FRAC_BITS = mtc_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mtc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mtc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [mtc_pkg::COORD_W-1:0]        pixel_row_i,
  input  logic [mtc_pkg::COORD_W-1:0]        pixel_col_i,
  input  logic [mtc_pkg::VALUE_W-1:0]        pixel_value_i,
  input  logic signed [mtc_pkg::EDGE_W-1:0]  left_limit_i,
  input  logic signed [mtc_pkg::EDGE_W-1:0]  right_limit_i,
  input  logic                               frame_end_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [mtc_pkg::MASS_W-1:0]         bright_count_o,
  output logic [mtc_pkg::FX_W-1:0]           centroid_row_fx_o,
  output logic [mtc_pkg::FX_W-1:0]           centroid_col_fx_o,
  output logic [mtc_pkg::PROBE_W-1:0]        probe_row_o,
  output logic [mtc_pkg::PROBE_W-1:0]        probe_col_o
);
  import mtc_pkg::*;

  logic           push, pop;
  mtc_frame_t     frame_in, frame_out;
  mtc_fifo_stat_t fifo_stat;

  // Classify and accumulate
  mtc_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_row_i   (pixel_row_i),
    .pixel_col_i   (pixel_col_i),
    .pixel_value_i (pixel_value_i),
    .left_limit_i  (left_limit_i),
    .right_limit_i (right_limit_i),
    .frame_end_i   (frame_end_i),
    .fifo_stat_i   (fifo_stat),
    .push_o        (push),
    .frame_o       (frame_in)
  );

  // Queue finished frames
  mtc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .frame_i (frame_in),
    .pop_i   (pop),
    .frame_o (frame_out),
    .stat_o  (fifo_stat)
  );

  // Divide and deliver
  mtc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .frame_i           (frame_out),
    .fifo_stat_i       (fifo_stat),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .bright_count_o    (bright_count_o),
    .centroid_row_fx_o (centroid_row_fx_o),
    .centroid_col_fx_o (centroid_col_fx_o),
    .probe_row_o       (probe_row_o),
    .probe_col_o       (probe_col_o)
  );

  `include "masked_threshold_centroid_top_macros.svh"

  // Queue is never overrun or read when empty
  `MTC_ASSERT_SAME(a_no_push_full, push, !fifo_stat.full, "frame pushed into full queue")
  `MTC_ASSERT_SAME(a_no_pop_empty, pop, !fifo_stat.empty, "frame popped from empty queue")
  // A finished frame is waiting in the queue right after its last pixel
  `MTC_ASSERT_NEXT(a_frame_queued, in_valid_i && !in_stall_o && frame_end_i,
                   !fifo_stat.empty, "finished frame missing from queue")
  // An empty frame gives all-zero centroids
  `MTC_ASSERT_SAME(a_zero_frame, out_valid_o && (bright_count_o == '0),
                   (centroid_row_fx_o == '0) && (centroid_col_fx_o == '0) &&
                   (probe_row_o == '0) && (probe_col_o == '0),
                   "non-zero centroid for empty frame")

endmodule

[design/mtc_front.sv]
// ----------------------------------------------------------------------------
// mtc_front
// Holds the configuration, classifies each pixel and accumulates the frame
// mass and moments; hands the totals of each finished frame to the queue.
// ----------------------------------------------------------------------------
module mtc_front #(
  parameter int unsigned MAX_COLS = 1024,
  parameter int unsigned MAX_ROWS = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [mtc_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [mtc_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [mtc_pkg::COORD_W-1:0]           pixel_row_i,
  input  logic [mtc_pkg::COORD_W-1:0]           pixel_col_i,
  input  logic [mtc_pkg::VALUE_W-1:0]           pixel_value_i,
  input  logic signed [mtc_pkg::EDGE_W-1:0]     left_limit_i,
  input  logic signed [mtc_pkg::EDGE_W-1:0]     right_limit_i,
  input  logic                                  frame_end_i,
  input  mtc_pkg::mtc_fifo_stat_t               fifo_stat_i,
  output logic                                  push_o,
  output mtc_pkg::mtc_frame_t                   frame_o
);
  import mtc_pkg::*;

  logic [COORD_W-1:0]       roi_first_col_q, roi_last_col_q;
  logic [COORD_W-1:0]       roi_first_row_q, roi_last_row_q;
  logic signed [THR_W-1:0]  thr_q;
  logic [MOM_W-1:0]         row_mom_q, row_mom_d;
  logic [MOM_W-1:0]         col_mom_q, col_mom_d;
  logic [MASS_W-1:0]        mass_q, mass_d;
  logic [MOM_W:0]           row_sum, col_sum;
  logic [MASS_W:0]          mass_sum;
  logic                     accept, hit;
  logic                     in_bounds, in_rows, in_cols, in_edges, bright;
  logic signed [EDGE_W-1:0] col_s;
  logic signed [THR_W-1:0]  val_s;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roi_first_col_q <= '0;
      roi_last_col_q  <= '1;
      roi_first_row_q <= '0;
      roi_last_row_q  <= '1;
      thr_q           <= THR_W'(128);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROI_FIRST_COL:    roi_first_col_q <= cfg_data_i[COORD_W-1:0];
        CFG_ROI_LAST_COL:     roi_last_col_q  <= cfg_data_i[COORD_W-1:0];
        CFG_ROI_FIRST_ROW:    roi_first_row_q <= cfg_data_i[COORD_W-1:0];
        CFG_ROI_LAST_ROW:     roi_last_row_q  <= cfg_data_i[COORD_W-1:0];
        CFG_BRIGHT_THRESHOLD: thr_q           <= signed'(cfg_data_i[THR_W-1:0]);
        default: ;
      endcase
    end
  end

  // Stall only while the queue has no room for a finished frame
  assign in_stall_o = fifo_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  // Classify the pixel
  assign col_s     = signed'(EDGE_W'(pixel_col_i));
  assign val_s     = signed'(THR_W'(pixel_value_i));
  assign in_bounds = (LIM_W'(pixel_row_i) < LIM_W'(MAX_ROWS)) &&
                     (LIM_W'(pixel_col_i) < LIM_W'(MAX_COLS));
  assign in_rows   = !pixel_row_i[0] &&
                     (pixel_row_i >= {roi_first_row_q[COORD_W-1:1], 1'b0}) &&
                     (pixel_row_i <= roi_last_row_q);
  assign in_cols   = (pixel_col_i >= roi_first_col_q) && (pixel_col_i <= roi_last_col_q);
  assign in_edges  = (col_s > left_limit_i) && (col_s < right_limit_i);
  assign bright    = val_s > thr_q;
  assign hit       = in_bounds && in_rows && in_cols && in_edges && bright;

  // Saturating accumulation, including the last pixel of the frame
  always_comb begin
    row_sum  = {1'b0, row_mom_q} + (MOM_W+1)'(pixel_row_i);
    col_sum  = {1'b0, col_mom_q} + (MOM_W+1)'(pixel_col_i);
    mass_sum = {1'b0, mass_q} + (MASS_W+1)'(1);
    row_mom_d = row_mom_q;
    col_mom_d = col_mom_q;
    mass_d    = mass_q;
    if (hit) begin
      row_mom_d = row_sum[MOM_W] ? '1 : row_sum[MOM_W-1:0];
      col_mom_d = col_sum[MOM_W] ? '1 : col_sum[MOM_W-1:0];
      mass_d    = mass_sum[MASS_W] ? '1 : mass_sum[MASS_W-1:0];
    end
  end

  // Hand the totals over on the last pixel
  assign push_o          = accept && frame_end_i;
  assign frame_o.mass    = mass_d;
  assign frame_o.row_mom = row_mom_d;
  assign frame_o.col_mom = col_mom_d;

  // Advance or clear the accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_mom_q <= '0;
      col_mom_q <= '0;
      mass_q    <= '0;
    end else if (accept) begin
      if (frame_end_i) begin
        row_mom_q <= '0;
        col_mom_q <= '0;
        mass_q    <= '0;
      end else begin
        row_mom_q <= row_mom_d;
        col_mom_q <= col_mom_d;
        mass_q    <= mass_d;
      end
    end
  end

endmodule

[design/mtc_fifo.sv]
// ----------------------------------------------------------------------------
// mtc_fifo
// Short queue of finished frame totals between the pixel front and the
// centroid divider.
// ----------------------------------------------------------------------------
module mtc_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  mtc_pkg::mtc_frame_t     frame_i,
  input  logic                    pop_i,
  output mtc_pkg::mtc_frame_t     frame_o,
  output mtc_pkg::mtc_fifo_stat_t stat_o
);
  import mtc_pkg::*;

  localparam int unsigned PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CntW = $clog2(QDEPTH + 1);

  mtc_frame_t        entry_q [QDEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign stat_o.full  = (count_q == CntW'(QDEPTH));
  assign stat_o.empty = (count_q == '0);
  assign frame_o      = entry_q[rd_ptr_q];

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= frame_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QDEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QDEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

[design/mtc_back.sv]
// ----------------------------------------------------------------------------
// mtc_back
// Takes frame totals from the queue, divides both moments by the count one
// quotient bit a cycle and holds the result in the output register.
// ----------------------------------------------------------------------------
module mtc_back #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mtc_pkg::mtc_frame_t            frame_i,
  input  mtc_pkg::mtc_fifo_stat_t        fifo_stat_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [mtc_pkg::MASS_W-1:0]     bright_count_o,
  output logic [mtc_pkg::FX_W-1:0]       centroid_row_fx_o,
  output logic [mtc_pkg::FX_W-1:0]       centroid_col_fx_o,
  output logic [mtc_pkg::PROBE_W-1:0]    probe_row_o,
  output logic [mtc_pkg::PROBE_W-1:0]    probe_col_o
);
  import mtc_pkg::*;

  // Dividend (2*moment + count) << FRAC_BITS, divisor 2*count
  localparam int unsigned NumW = MOM_W + 2;
  localparam int unsigned DvdW = NumW + FRAC_BITS;
  localparam int unsigned DvsW = MASS_W + 1;
  localparam int unsigned RemW = MASS_W + 2;
  localparam int unsigned QW   = (FRAC_BITS + PROBE_W > FX_W) ? FRAC_BITS + PROBE_W : FX_W;
  localparam int unsigned CntW = $clog2(DvdW + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CntW-1:0]   step_q;
  logic [MASS_W-1:0] mass_q;
  logic [DvsW-1:0]   dvs_q;
  logic [DvdW-1:0]   dvd_row_q, dvd_col_q;
  logic [RemW-1:0]   rem_row_q, rem_col_q;
  logic [QW-1:0]     quo_row_q, quo_col_q;
  logic [NumW-1:0]   num_row, num_col;
  logic [RemW:0]     step_row, step_col;
  logic              load_out, zero_mass;

  // One restoring step: quotient bit on top, new remainder below
  function automatic logic [RemW:0] div_step(input logic [RemW-1:0] rem,
                                             input logic            dbit,
                                             input logic [DvsW-1:0] dvs);
    logic [RemW-1:0] rs;
    rs = {rem[RemW-2:0], dbit};
    if (rs >= RemW'(dvs)) begin
      div_step = {1'b1, rs - RemW'(dvs)};
    end else begin
      div_step = {1'b0, rs};
    end
  endfunction

  assign num_row  = NumW'({frame_i.row_mom, 1'b0}) + NumW'(frame_i.mass);
  assign num_col  = NumW'({frame_i.col_mom, 1'b0}) + NumW'(frame_i.mass);
  assign step_row = div_step(rem_row_q, dvd_row_q[DvdW-1], dvs_q);
  assign step_col = div_step(rem_col_q, dvd_col_q[DvdW-1], dvs_q);

  assign pop_o     = (state_q == ST_IDLE) && !fifo_stat_i.empty;
  assign load_out  = (state_q == ST_DONE) && (!out_valid_o || !out_stall_i);
  assign zero_mass = (mass_q == '0);

  // Sequence load, divide and hand-off
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (pop_o) state_d = ST_DIV;
      ST_DIV:  if (step_q == CntW'(1)) state_d = ST_DONE;
      ST_DONE: if (load_out) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        step_q <= CntW'(DvdW);
      end else if (state_q == ST_DIV) begin
        step_q <= step_q - CntW'(1);
      end
    end
  end

  // Load operands, then shift one quotient bit in per cycle
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      mass_q    <= frame_i.mass;
      dvs_q     <= {frame_i.mass, 1'b0};
      dvd_row_q <= DvdW'(num_row) << FRAC_BITS;
      dvd_col_q <= DvdW'(num_col) << FRAC_BITS;
      rem_row_q <= '0;
      rem_col_q <= '0;
      quo_row_q <= '0;
      quo_col_q <= '0;
    end else if (state_q == ST_DIV) begin
      dvd_row_q <= dvd_row_q << 1;
      dvd_col_q <= dvd_col_q << 1;
      rem_row_q <= step_row[RemW-1:0];
      rem_col_q <= step_col[RemW-1:0];
      quo_row_q <= {quo_row_q[QW-2:0], step_row[RemW]};
      quo_col_q <= {quo_col_q[QW-2:0], step_col[RemW]};
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (load_out) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      bright_count_o <= mass_q;
      if (zero_mass) begin
        centroid_row_fx_o <= '0;
        centroid_col_fx_o <= '0;
        probe_row_o       <= '0;
        probe_col_o       <= '0;
      end else begin
        centroid_row_fx_o <= quo_row_q[FX_W-1:0];
        centroid_col_fx_o <= quo_col_q[FX_W-1:0];
        probe_row_o       <= {quo_row_q[FRAC_BITS+1 +: PROBE_W-1], 1'b0};
        probe_col_o       <= {quo_col_q[FRAC_BITS+1 +: PROBE_W-1], 1'b0};
      end
    end
  end

endmodule

[test/masked_threshold_centroid_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_threshold_centroid_top_test
// Drives raster pixels and region settings into the centroid block. A shadow
// copy of the accumulators and registers predicts each frame result, and the
// result port is checked against it with random idle and stall on both sides.
// ----------------------------------------------------------------------------
module masked_threshold_centroid_top_test;
  import mtc_pkg::*;

  localparam int unsigned      FRAC         = FRAC_BITS_DEF;
  localparam longint unsigned  MOM_TOP      = (64'd1 << MOM_W) - 1;
  localparam longint unsigned  MASS_TOP     = (64'd1 << MASS_W) - 1;
  localparam int unsigned      DRAIN_CYCLES = 60;
  localparam int unsigned      HOLD_OFF     = 400;
  localparam int               ITEM_TARGET  = 1150;

  typedef struct {
    logic [COORD_W-1:0]       row;
    logic [COORD_W-1:0]       col;
    logic [VALUE_W-1:0]       value;
    logic signed [EDGE_W-1:0] left;
    logic signed [EDGE_W-1:0] right;
    logic                     fend;
  } pixel_t;

  typedef struct {
    logic [MASS_W-1:0]  count;
    logic [FX_W-1:0]    row_fx;
    logic [FX_W-1:0]    col_fx;
    logic [PROBE_W-1:0] row_probe;
    logic [PROBE_W-1:0] col_probe;
  } centroid_t;

  // Block inputs, all known from time zero
  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx = CFG_ROI_FIRST_COL;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic [COORD_W-1:0]       pixel_row = '0;
  logic [COORD_W-1:0]       pixel_col = '0;
  logic [VALUE_W-1:0]       pixel_value = '0;
  logic signed [EDGE_W-1:0] left_limit = '0;
  logic signed [EDGE_W-1:0] right_limit = '0;
  logic                     frame_end = 1'b0;
  logic                     out_stall = 1'b0;

  // Block outputs
  logic                     in_stall;
  logic                     out_valid;
  logic [MASS_W-1:0]        bright_count;
  logic [FX_W-1:0]          centroid_row_fx;
  logic [FX_W-1:0]          centroid_col_fx;
  logic [PROBE_W-1:0]       probe_row;
  logic [PROBE_W-1:0]       probe_col;

  // Register shadow, at reset values
  logic [COORD_W-1:0]       sh_first_col = 10'd0;
  logic [COORD_W-1:0]       sh_last_col  = 10'd1023;
  logic [COORD_W-1:0]       sh_first_row = 10'd0;
  logic [COORD_W-1:0]       sh_last_row  = 10'd1023;
  logic signed [THR_W-1:0]  sh_thr       = 9'sd128;

  // Predicted accumulators
  longint unsigned          row_acc  = 0;
  longint unsigned          col_acc  = 0;
  longint unsigned          mass_acc = 0;

  pixel_t                   pixel_q[$];
  centroid_t                centroid_q[$];
  pixel_t                   cur_pix;
  int                       n_queued = 0;
  int                       n_errors = 0;
  int unsigned              in_wait = 0;
  int unsigned              in_calm = 0;
  int unsigned              stall_left = 0;
  int unsigned              out_calm = 0;
  bit                       squeeze_arm = 1'b0;

  masked_threshold_centroid_top u_top (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .pixel_row_i       (pixel_row),
    .pixel_col_i       (pixel_col),
    .pixel_value_i     (pixel_value),
    .left_limit_i      (left_limit),
    .right_limit_i     (right_limit),
    .frame_end_i       (frame_end),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .bright_count_o    (bright_count),
    .centroid_row_fx_o (centroid_row_fx),
    .centroid_col_fx_o (centroid_col_fx),
    .probe_row_o       (probe_row),
    .probe_col_o       (probe_col)
  );

  // Clock
  always #6 clk = ~clk;

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    n_errors++;
  endtask

  // Idle length for the next transaction; occasional calm stretches of none
  task automatic draw_gap(inout int unsigned calm, output int unsigned gap);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else if ($urandom_range(24, 0) == 0) begin
      calm = $urandom_range(60, 15);
      gap = 0;
    end else begin
      gap = $urandom_range(11, 0);
    end
  endtask

  // Fold one accepted pixel into the predicted sums; emit on frame end
  task automatic fold_pixel(input pixel_t p);
    bit              hit;
    longint unsigned q_r;
    longint unsigned q_c;
    longint unsigned den;
    centroid_t       c;
    hit = (p.row[0] == 1'b0)
       && (p.row >= {sh_first_row[COORD_W-1:1], 1'b0}) && (p.row <= sh_last_row)
       && (p.col >= sh_first_col) && (p.col <= sh_last_col)
       && ($signed({2'b00, p.col}) > p.left) && ($signed({2'b00, p.col}) < p.right)
       && ($signed({1'b0, p.value}) > sh_thr);
    if (hit) begin
      row_acc  = (row_acc + p.row > MOM_TOP) ? MOM_TOP : row_acc + p.row;
      col_acc  = (col_acc + p.col > MOM_TOP) ? MOM_TOP : col_acc + p.col;
      mass_acc = (mass_acc + 1 > MASS_TOP) ? MASS_TOP : mass_acc + 1;
    end
    if (p.fend) begin
      if (mass_acc == 0) begin
        c = '{default: '0};
      end else begin
        // sum/count + 1/2 in fixed point, truncated
        den = mass_acc << 1;
        q_r = ((row_acc << (FRAC + 1)) + (mass_acc << FRAC)) / den;
        q_c = ((col_acc << (FRAC + 1)) + (mass_acc << FRAC)) / den;
        c.count     = MASS_W'(mass_acc);
        c.row_fx    = FX_W'(q_r);
        c.col_fx    = FX_W'(q_c);
        c.row_probe = PROBE_W'((q_r >> FRAC) & ~64'd1);
        c.col_probe = PROBE_W'((q_c >> FRAC) & ~64'd1);
      end
      centroid_q.push_back(c);
      row_acc  = 0;
      col_acc  = 0;
      mass_acc = 0;
    end
  endtask

  // Pixel driver: hold while stalled, pause between transactions
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        fold_pixel(cur_pix);
        draw_gap(in_calm, in_wait);
      end
      if (!in_valid || !in_stall) begin
        if (in_wait == 0 && pixel_q.size() != 0) begin
          cur_pix = pixel_q.pop_front();
          pixel_row   <= cur_pix.row;
          pixel_col   <= cur_pix.col;
          pixel_value <= cur_pix.value;
          left_limit  <= cur_pix.left;
          right_limit <= cur_pix.right;
          frame_end   <= cur_pix.fend;
          in_valid    <= 1'b1;
        end else begin
          if (in_wait != 0) in_wait--;
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check against the oldest prediction, stall at random
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (centroid_q.size() == 0) begin
          flag_mismatch("result with nothing expected, count", bright_count, 0);
        end else begin
          if (bright_count != centroid_q[0].count)
            flag_mismatch("bright_count", bright_count, centroid_q[0].count);
          if (centroid_row_fx != centroid_q[0].row_fx)
            flag_mismatch("centroid_row_fx", centroid_row_fx, centroid_q[0].row_fx);
          if (centroid_col_fx != centroid_q[0].col_fx)
            flag_mismatch("centroid_col_fx", centroid_col_fx, centroid_q[0].col_fx);
          if (probe_row != centroid_q[0].row_probe)
            flag_mismatch("probe_row", probe_row, centroid_q[0].row_probe);
          if (probe_col != centroid_q[0].col_probe)
            flag_mismatch("probe_col", probe_col, centroid_q[0].col_probe);
          void'(centroid_q.pop_front());
        end
        draw_gap(out_calm, stall_left);
      end
      // Long hold-off so that frames back up into the input
      if (squeeze_arm && out_valid) begin
        stall_left  = HOLD_OFF;
        squeeze_arm = 1'b0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ROI_FIRST_COL:    sh_first_col = data;
      CFG_ROI_LAST_COL:     sh_last_col  = data;
      CFG_ROI_FIRST_ROW:    sh_first_row = data;
      CFG_ROI_LAST_ROW:     sh_last_row  = data;
      CFG_BRIGHT_THRESHOLD: sh_thr       = data[THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_region(input int fc, input int lc, input int fr, input int lr,
                            input int thr);
    logic [THR_W-1:0] thr_bits;
    thr_bits = thr[THR_W-1:0];
    write_reg(CFG_ROI_FIRST_COL, CFG_DATA_W'(fc));
    write_reg(CFG_ROI_LAST_COL, CFG_DATA_W'(lc));
    write_reg(CFG_ROI_FIRST_ROW, CFG_DATA_W'(fr));
    write_reg(CFG_ROI_LAST_ROW, CFG_DATA_W'(lr));
    // Top data bit is unused by the threshold; toggle it anyway
    write_reg(CFG_BRIGHT_THRESHOLD, {1'($urandom_range(1, 0)), thr_bits});
  endtask

  // Random region, mostly ordered, sometimes inverted or full
  task automatic shuffle_region();
    int a;
    int b;
    int c;
    int d;
    int thr;
    a = $urandom_range(1023, 0);
    b = $urandom_range(1023, 0);
    c = $urandom_range(1023, 0);
    d = $urandom_range(1023, 0);
    thr = int'($urandom_range(275, 0)) - 20;
    if ($urandom_range(5, 0) == 0) begin
      set_region(0, 1023, 0, 1023, thr);
    end else if ($urandom_range(5, 0) == 0) begin
      set_region(a, b, c, d, thr);
    end else begin
      set_region(a < b ? a : b, a < b ? b : a, c < d ? c : d, c < d ? d : c, thr);
    end
  endtask

  task automatic push_pix(input int row, input int col, input int value, input int left,
                          input int right, input bit fend);
    pixel_t p;
    p.row   = COORD_W'(row);
    p.col   = COORD_W'(col);
    p.value = VALUE_W'(value);
    p.left  = EDGE_W'(left);
    p.right = EDGE_W'(right);
    p.fend  = fend;
    pixel_q.push_back(p);
    n_queued++;
  endtask

  function automatic int pick(input int lo, input int hi);
    if (lo <= hi) return int'($urandom_range(hi, lo));
    return int'($urandom_range(1023, 0));
  endfunction

  // One pixel: mostly inside the region and the edges, some noise
  task automatic queue_pixel(input bit fend);
    int row;
    int col;
    int val;
    int lft;
    int rgt;
    int t;
    t = int'(sh_thr);
    if ($urandom_range(3, 0) != 0) begin
      row = pick(int'({sh_first_row[COORD_W-1:1], 1'b0}), int'(sh_last_row));
      if ($urandom_range(4, 0) != 0) row = row & ~1;
      col = pick(int'(sh_first_col), int'(sh_last_col));
    end else begin
      row = $urandom_range(1023, 0);
      col = $urandom_range(1023, 0);
    end
    val = $urandom_range(255, 0);
    if ($urandom_range(2, 0) == 0) begin
      val = t + int'($urandom_range(2, 0)) - 1;
      if (val < 0) val = 0;
      if (val > 255) val = 255;
    end
    lft = int'($urandom_range(col, 0)) - 1;
    rgt = col + 1 + int'($urandom_range(1023 - col, 0));
    if ($urandom_range(7, 0) == 0) lft = col;
    else if ($urandom_range(7, 0) == 0) rgt = col;
    if ($urandom_range(7, 0) == 0) begin
      lft = int'($urandom_range(1025, 0)) - 1;
      rgt = int'($urandom_range(1025, 0)) - 1;
    end
    push_pix(row, col, val, lft, rgt, fend);
  endtask

  // Frames of random length, each closed by a frame end
  task automatic queue_phase(input int frames, input int longest);
    int n;
    for (int f = 0; f < frames; f++) begin
      n = ($urandom_range(19, 0) == 0) ? longest : int'($urandom_range(8, 1));
      for (int k = 0; k < n; k++) queue_pixel(k == n - 1);
    end
  endtask

  // Wait for all pixels taken and all results seen, then let the block idle
  task automatic settle();
    @(negedge clk);
    while (pixel_q.size() != 0 || in_valid || centroid_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Stimulus and end of run
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames under reset settings
    push_pix(0, 0, 255, -1, 1024, 1'b1);          // single bright pixel at the origin
    push_pix(1, 5, 255, -1, 1024, 1'b1);          // odd row only: empty frame
    push_pix(1022, 1023, 255, -1, 1024, 1'b0);    // far corner
    push_pix(1022, 1023, 129, 1022, 1024, 1'b1);  // just above threshold, counted last
    push_pix(10, 10, 128, -1, 1024, 1'b0);        // equal to threshold: dark
    push_pix(10, 10, 129, 10, 1024, 1'b0);        // on the left edge: out
    push_pix(10, 10, 200, 9, 10, 1'b0);           // on the right edge: out
    push_pix(10, 10, 200, 9, 11, 1'b1);
    push_pix(3, 100, 0, 0, 0, 1'b0);
    push_pix(4, 100, 255, 99, 101, 1'b0);
    push_pix(6, 101, 255, 99, 102, 1'b0);
    push_pix(8, 103, 255, -1, 1024, 1'b1);        // fractional centroid
    push_pix(1023, 0, 255, -1, 1024, 1'b1);
    settle();

    // Lowest threshold over the full frame
    set_region(0, 1023, 0, 1023, -20);
    queue_phase(12, 40);
    settle();

    // Single-pixel region at the far corner, odd first row
    set_region(1023, 1023, 1023, 1023, 254);
    queue_phase(8, 8);
    settle();

    // Inverted region: nothing counts
    set_region(700, 100, 5, 3, 0);
    queue_phase(6, 8);
    settle();

    // Highest threshold, odd first row
    set_region(0, 1023, 5, 1023, 255);
    queue_phase(6, 8);
    settle();

    // Back up the result side while frames keep coming
    shuffle_region();
    squeeze_arm = 1'b1;
    queue_phase(20, 6);
    settle();

    while (n_queued < ITEM_TARGET) begin
      shuffle_region();
      queue_phase(15, 60);
      settle();
    end

    if (n_errors == 0) begin
      $display("masked_threshold_centroid_top_test: clean");
    end else begin
      $display("masked_threshold_centroid_top_test: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("masked_threshold_centroid_top_test: errors");
    $finish;
  end

endmodule
